/* rtl/vrb_pkg.sv */
// Package: types, constants and the sine table of the velocity relaxation blend.
package vrb_pkg;

  // Sizes of the arithmetic
  localparam int VALUE_WIDTH        = 16;
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int OUT_BITS           = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
  localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int SINE_W             = 14;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Divisors (2j)*(2j+1) of the Taylor series terms, j = 1..10
  localparam logic [63:0] TAYLOR_DEN [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PSI_BAND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSI_BAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSI_RECIP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_VELOCITY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_ENABLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACH_ENABLE = 3'd6;

  // Where the level-set sum falls relative to the interface bands
  typedef enum logic [1:0] {
    REGION_AIR,
    REGION_WATER,
    REGION_RAMP
  } region_e;

  // One input transaction
  typedef struct packed {
    logic signed [15:0] phi_here;
    logic signed [15:0] phi_next;
    logic signed [15:0] vel_old;
    logic signed [15:0] target_vel;
    logic        [15:0] gen_weight;
    logic        [15:0] beach_weight;
    logic               in_gen_zone;
    logic               in_beach_zone;
  } in_item_t;

  // One output transaction
  typedef struct packed {
    logic signed [15:0] vel_new;
    logic               target_used;
  } out_item_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_ENTRIES+1];

  // Build round(32768*sin(pi*k/N)/pi) by a fixed-point Taylor series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic        [63:0] k2;
    logic        [63:0] a;
    logic        [63:0] a2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      k2 = (k <= SINE_TABLE_ENTRIES - k) ? 64'(k) : 64'(SINE_TABLE_ENTRIES - k);
      a = (PI_Q30 * k2) / SINE_TABLE_ENTRIES;
      a2 = (a * a) >> 30;
      term = a;
      sum = $signed(a);
      for (int j = 1; j <= 10; j++) begin
        term = ((term * a2) >> 30) / TAYLOR_DEN[j];
        if ((j & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      rom[k] = SINE_W'(($unsigned(sum) * 64'd32768 + PI_Q30 / 2) / PI_Q30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/vrb_heaviside.sv */
// Smoothed Heaviside lookup: sine ramp between the bands, constant outside.
module vrb_heaviside
  import vrb_pkg::*;
(
  input  logic [15:0] ramp_pos_i,
  input  region_e     region_i,
  output logic [15:0] heavi_o
);

  logic [31:0]           idx_full;
  logic [SINE_IDX_W-1:0] idx;
  logic signed [17:0]    h_diff;
  logic [16:0]           h_half;
  logic [15:0]           h_ramp;

  // Round the ramp position onto the table grid and clamp at the end
  assign idx_full = (32'(ramp_pos_i) * 32'(SINE_TABLE_ENTRIES) + 32'd16384) >> 15;
  assign idx = (idx_full > 32'(SINE_TABLE_ENTRIES)) ? SINE_IDX_W'(SINE_TABLE_ENTRIES)
                                                    : idx_full[SINE_IDX_W-1:0];

  // H = (1 - t - sin/pi) / 2, floored and held inside [0, 1]
  always_comb begin
    h_diff = $signed({2'b00, ONE_Q15}) - $signed({2'b00, ramp_pos_i})
             - $signed({4'b0000, SINE_ROM[idx]});
    h_half = h_diff[17] ? 17'd0 : h_diff[17:1];
    h_ramp = (h_half > {1'b0, ONE_Q15}) ? ONE_Q15 : h_half[15:0];
  end

  // Select by region
  always_comb begin
    case (region_i)
      REGION_AIR:   heavi_o = 16'd0;
      REGION_WATER: heavi_o = ONE_Q15;
      REGION_RAMP:  heavi_o = h_ramp;
      default:      heavi_o = 16'd0;
    endcase
  end

endmodule

/* rtl/velocity_relaxation_blend_top.sv */
// Top level of the velocity relaxation blend: config registers and 7-stage datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | to block  | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | from block| out_valid_o / out_stall_i | out_data_o (out_item_t)
//   cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction a cycle while out_stall_i is low; each result passes through stage registers s1_q to s6_q and out_q.
// The depth is set by the multiplier stages: ramp product, blend products, the
// split Heaviside product and the beach product, each followed by a register.
// Stages hold their contents under a stall and empty stages fill, so the input
// side keeps taking transactions while a result waits at the output register, until every stage is full.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module velocity_relaxation_blend_top
  import vrb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  typedef struct packed {
    region_e            region;
    logic        [16:0] mag;
    logic signed [15:0] vel;
    logic signed [15:0] tgt;
    logic        [15:0] w;
    logic        [15:0] b;
    logic        [30:0] a;
    logic               used;
    logic               beach;
  } s1_t;

  typedef struct packed {
    region_e            region;
    logic        [15:0] t;
    logic signed [15:0] vel;
    logic        [15:0] b;
    logic signed [47:0] at;
    logic signed [47:0] aa;
    logic signed [32:0] wv;
    logic signed [32:0] wa;
    logic               used;
    logic               beach;
  } s2_t;

  typedef struct packed {
    logic        [15:0] h;
    logic signed [49:0] d;
    logic signed [49:0] q;
    logic signed [15:0] vel;
    logic        [15:0] b;
    logic               used;
    logic               beach;
  } s3_t;

  typedef struct packed {
    logic        [39:0] pl;
    logic signed [42:0] ph;
    logic signed [49:0] q;
    logic signed [15:0] vel;
    logic        [15:0] b;
    logic               used;
    logic               beach;
  } s4_t;

  typedef struct packed {
    logic signed [15:0] velg;
    logic signed [15:0] vel;
    logic        [15:0] b;
    logic               used;
    logic               beach;
  } s5_t;

  typedef struct packed {
    logic signed [15:0] vel2;
    logic signed [32:0] bprod;
    logic               used;
    logic               beach;
  } s6_t;

  // Saturate to a signed value of OUT_BITS bits, sign-extended to 16
  function automatic logic signed [15:0] sat_out(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] r;
    hi = (32'sd1 <<< (OUT_BITS - 1)) - 32'sd1;
    lo = -hi - 32'sd1;
    r = (v > hi) ? hi : ((v < lo) ? lo : v);
    return r[15:0];
  endfunction

  logic [14:0]        psi_q;
  logic [14:0]        epsi_q;
  logic [15:0]        recip_q;
  logic [15:0]        ramp_q;
  logic signed [15:0] air_q;
  logic               gen_en_q;
  logic               beach_en_q;

  logic [7:1] v_q;
  logic [7:1] adv;

  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  s3_t       s3_d, s3_q;
  s4_t       s4_d, s4_q;
  s5_t       s5_d, s5_q;
  s6_t       s6_d, s6_q;
  out_item_t out_d, out_q;

  logic [15:0] heavi;

  // Configuration registers: always ready, out-of-range indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psi_q      <= 15'd0;
      epsi_q     <= 15'd1024;
      recip_q    <= 16'd256;
      ramp_q     <= ONE_Q15;
      air_q      <= 16'sd0;
      gen_en_q   <= 1'b0;
      beach_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PSI_BAND:     psi_q      <= cfg_data_i[14:0];
        CFG_EPSI_BAND:    epsi_q     <= cfg_data_i[14:0];
        CFG_EPSI_RECIP:   recip_q    <= cfg_data_i;
        CFG_RAMP_GAIN:    ramp_q     <= cfg_data_i;
        CFG_AIR_VELOCITY: air_q      <= $signed(cfg_data_i);
        CFG_GEN_ENABLE:   gen_en_q   <= cfg_data_i[0];
        CFG_BEACH_ENABLE: beach_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when it is empty or its successor moves on
  always_comb begin
    adv[7] = !v_q[7] || !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = v_q[7];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= 7; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: level-set sum, band compare, weight limits, (1-w)*R
  always_comb begin
    logic signed [16:0] s_sum;
    logic signed [16:0] neg2e;
    logic signed [16:0] neg2p;
    logic        [15:0] w_lim;
    logic        [15:0] r_lim;
    logic        [31:0] a_full;
    s_sum = {in_data_i.phi_here[15], in_data_i.phi_here}
          + {in_data_i.phi_next[15], in_data_i.phi_next};
    neg2e = -$signed({1'b0, epsi_q, 1'b0});
    neg2p = -$signed({1'b0, psi_q, 1'b0});
    if (s_sum < neg2e) begin
      s1_d.region = REGION_AIR;
    end else if (s_sum >= neg2p) begin
      s1_d.region = REGION_WATER;
    end else begin
      s1_d.region = REGION_RAMP;
    end
    w_lim = (in_data_i.gen_weight > ONE_Q15) ? ONE_Q15 : in_data_i.gen_weight;
    r_lim = (ramp_q > ONE_Q15) ? ONE_Q15 : ramp_q;
    a_full = 32'(ONE_Q15 - w_lim) * 32'(r_lim);
    s1_d.mag   = 17'(-s_sum);
    s1_d.vel   = in_data_i.vel_old;
    s1_d.tgt   = in_data_i.target_vel;
    s1_d.w     = w_lim;
    s1_d.b     = (in_data_i.beach_weight > ONE_Q15) ? ONE_Q15 : in_data_i.beach_weight;
    s1_d.a     = a_full[30:0];
    s1_d.used  = gen_en_q && in_data_i.in_gen_zone;
    s1_d.beach = beach_en_q && in_data_i.in_beach_zone;
  end

  // Stage 2: ramp position and the four blend products
  always_comb begin
    logic        [32:0] tprod;
    logic        [32:0] trnd;
    logic signed [47:0] a_s;
    logic signed [47:0] tgt_s;
    logic signed [47:0] air_s;
    logic signed [32:0] w_s;
    logic signed [32:0] vel_s;
    logic signed [32:0] air_n;
    tprod = 33'(s1_q.mag) * 33'(recip_q);
    trnd  = tprod + 33'd8;
    a_s   = $signed({17'd0, s1_q.a});
    tgt_s = 48'(s1_q.tgt);
    air_s = 48'(air_q);
    w_s   = $signed({17'd0, s1_q.w});
    vel_s = 33'(s1_q.vel);
    air_n = 33'(air_q);
    s2_d.region = s1_q.region;
    s2_d.t      = (trnd[32:4] > 29'(ONE_Q15)) ? ONE_Q15 : trnd[19:4];
    s2_d.vel    = s1_q.vel;
    s2_d.b      = s1_q.b;
    s2_d.at     = a_s * tgt_s;
    s2_d.aa     = a_s * air_s;
    s2_d.wv     = w_s * vel_s;
    s2_d.wa     = w_s * air_n;
    s2_d.used   = s1_q.used;
    s2_d.beach  = s1_q.beach;
  end

  // Stage 3: Heaviside value, water term P and air term Q, difference P - Q
  vrb_heaviside u_heaviside (
    .ramp_pos_i (s2_q.t),
    .region_i   (s2_q.region),
    .heavi_o    (heavi)
  );

  always_comb begin
    logic signed [49:0] p_sum;
    logic signed [49:0] q_sum;
    p_sum = 50'(s2_q.at) + (50'(s2_q.wv) <<< 15);
    q_sum = (50'(s2_q.vel) <<< 30) + 50'(s2_q.aa) + (50'(s2_q.wa) <<< 15);
    s3_d.h     = heavi;
    s3_d.d     = p_sum - q_sum;
    s3_d.q     = q_sum;
    s3_d.vel   = s2_q.vel;
    s3_d.b     = s2_q.b;
    s3_d.used  = s2_q.used;
    s3_d.beach = s2_q.beach;
  end

  // Stage 4: H * (P - Q), split into a low and a high partial product
  always_comb begin
    logic signed [42:0] h_s;
    logic signed [42:0] dh_s;
    h_s  = $signed({27'd0, s3_q.h});
    dh_s = 43'($signed(s3_q.d[49:24]));
    s4_d.pl    = 40'(s3_q.h) * 40'(s3_q.d[23:0]);
    s4_d.ph    = h_s * dh_s;
    s4_d.q     = s3_q.q;
    s4_d.vel   = s3_q.vel;
    s4_d.b     = s3_q.b;
    s4_d.used  = s3_q.used;
    s4_d.beach = s3_q.beach;
  end

  // Stage 5: join the partial products with Q, round once and saturate
  always_comb begin
    logic signed [67:0] acc;
    acc = (68'(s4_q.ph) <<< 24) + $signed({28'd0, s4_q.pl}) + (68'(s4_q.q) <<< 15)
        + (68'sd1 <<< 44);
    s5_d.velg  = sat_out(32'($signed(acc[67:45])));
    s5_d.vel   = s4_q.vel;
    s5_d.b     = s4_q.b;
    s5_d.used  = s4_q.used;
    s5_d.beach = s4_q.beach;
  end

  // Stage 6: pick the generation result, then the beach product
  always_comb begin
    logic signed [32:0] b_s;
    logic signed [32:0] v_s;
    s6_d.vel2  = s5_q.used ? s5_q.velg : s5_q.vel;
    b_s        = $signed({17'd0, s5_q.b});
    v_s        = 33'(s6_d.vel2);
    s6_d.bprod = b_s * v_s;
    s6_d.used  = s5_q.used;
    s6_d.beach = s5_q.beach;
  end

  // Stage 7: round and saturate the beach product into the output register, or pass vel2 when beach is clear
  always_comb begin
    logic signed [33:0] bsum;
    bsum = 34'(s6_q.bprod) + 34'sd16384;
    out_d.vel_new     = s6_q.beach ? sat_out(32'($signed(bsum[33:15]))) : s6_q.vel2;
    out_d.target_used = s6_q.used;
  end

  // Payload registers: load on advance, hold under stall
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q <= s1_d;
    end
    if (adv[2]) begin
      s2_q <= s2_d;
    end
    if (adv[3]) begin
      s3_q <= s3_d;
    end
    if (adv[4]) begin
      s4_q <= s4_d;
    end
    if (adv[5]) begin
      s5_q <= s5_d;
    end
    if (adv[6]) begin
      s6_q <= s6_d;
    end
    if (adv[7]) begin
      out_q <= out_d;
    end
  end

endmodule

/* dv/velocity_relaxation_blend_top_tb.sv */
// Self-checking testbench for the velocity relaxation blend: directed faces, random sweeps.
module velocity_relaxation_blend_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrb_pkg::*;

  localparam int PIPE_DEPTH = 7;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_FACES = 73;
  localparam int NUM_PHASES = 10;
  localparam int PRESSURE_PHASE = 4;
  localparam int PRESSURE_CYCLES = 90;
  localparam longint UNITY = 32768;
  localparam longint SAT_HI = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Expected-face store with its own copy of the registers and the sine ramp table
  class relax_scoreboard;
    longint    sine_q15 [SINE_TABLE_ENTRIES+1];
    longint    psi_w;
    longint    epsi_w;
    longint    recip_w;
    longint    ramp_w;
    longint    air_w;
    bit        gen_on;
    bit        beach_on;
    out_item_t pending_faces [$];
    int        mismatches;

    function new();
      longint unsigned n, k2, a, a2, term;
      longint          sum;
      n = SINE_TABLE_ENTRIES;
      // Taylor series of sin in Q30, folded about the midpoint
      for (longint unsigned k = 0; k <= n; k++) begin
        k2 = (k <= n - k) ? k : n - k;
        a = PI_Q30 * k2 / n;
        a2 = (a * a) >> 30;
        term = a;
        sum = longint'(a);
        for (int j = 1; j <= 10; j++) begin
          term = ((term * a2) >> 30) / longint'((2 * j) * (2 * j + 1));
          if (j % 2 == 1) begin
            sum -= longint'(term);
          end else begin
            sum += longint'(term);
          end
        end
        if (sum < 0) sum = 0;
        sine_q15[k] = longint'((longint'(sum) * 32768 + PI_Q30 / 2) / PI_Q30);
      end
      psi_w = 0;
      epsi_w = 1024;
      recip_w = 256;
      ramp_w = UNITY;
      air_w = 0;
      gen_on = 1'b0;
      beach_on = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_PSI_BAND:     psi_w = longint'(data[14:0]);
        CFG_EPSI_BAND:    epsi_w = longint'(data[14:0]);
        CFG_EPSI_RECIP:   recip_w = longint'(data);
        CFG_RAMP_GAIN:    ramp_w = longint'(data);
        CFG_AIR_VELOCITY: air_w = longint'($signed(data));
        CFG_GEN_ENABLE:   gen_on = data[0];
        CFG_BEACH_ENABLE: beach_on = data[0];
        default: ;
      endcase
    endfunction

    function longint round_down(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint clamp_vel(longint v);
      return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    endfunction

    // Smoothed Heaviside of the level-set sum, Q1.15
    function longint water_fraction(longint s);
      longint t, idx, h;
      if (s < -2 * epsi_w) return 0;
      if (s >= -2 * psi_w) return UNITY;
      t = ((-s) * recip_w + 8) >>> 4;
      if (t > UNITY) t = UNITY;
      idx = (t * SINE_TABLE_ENTRIES + 16384) >>> 15;
      if (idx > SINE_TABLE_ENTRIES) idx = SINE_TABLE_ENTRIES;
      h = UNITY - t - sine_q15[idx];
      if (h < 0) h = 0;
      h = h >>> 1;
      return (h > UNITY) ? UNITY : h;
    endfunction

    function out_item_t relax_face(in_item_t f);
      out_item_t res;
      longint    s, vel, tgt, w, b, r, h, omh, a, acc;
      bit        used;
      s = longint'($signed(f.phi_here)) + longint'($signed(f.phi_next));
      vel = longint'($signed(f.vel_old));
      tgt = longint'($signed(f.target_vel));
      w = (f.gen_weight > 16'h8000) ? UNITY : longint'(f.gen_weight);
      b = (f.beach_weight > 16'h8000) ? UNITY : longint'(f.beach_weight);
      used = gen_on && f.in_gen_zone;
      // Blend toward ramped target in water and air velocity in air
      if (used) begin
        r = (ramp_w > UNITY) ? UNITY : ramp_w;
        h = water_fraction(s);
        omh = UNITY - h;
        a = (UNITY - w) * r;
        acc = a * tgt * h + w * h * vel * UNITY + omh * vel * (longint'(1) << 30)
            + a * air_w * omh + w * omh * air_w * UNITY;
        vel = clamp_vel(round_down(acc, 45));
      end
      if (beach_on && f.in_beach_zone) vel = clamp_vel(round_down(b * vel, 15));
      res.vel_new = 16'(vel);
      res.target_used = used;
      return res;
    endfunction

    function void note_face(in_item_t f);
      pending_faces.push_back(relax_face(f));
    endfunction

    function void check_face(out_item_t got);
      out_item_t want;
      if (pending_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: vel_new %0d target_used %0b",
                   got.vel_new, got.target_used);
        return;
      end
      want = pending_faces.pop_front();
      if (got.vel_new !== want.vel_new || got.target_used !== want.target_used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: vel_new exp %0d got %0d, target_used exp %0b got %0b",
                   $realtime, want.vel_new, got.vel_new, want.target_used, got.target_used);
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i;
  logic            in_stall_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_item_t       out_data_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]     cfg_data_i;

  relax_scoreboard blend_sb;
  bit              pressure_req = 1'b0;
  bit              hold_active = 1'b0;
  bit              idling_on = 1'b0;

  velocity_relaxation_blend_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Offer one face and hold it until the block takes it
  task automatic offer_face(in_item_t f);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    blend_sb.note_face(f);
  endtask

  task automatic pause_offer(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (blend_sb.pending_faces.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    blend_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] psi, logic [15:0] epsi, logic [15:0] recip,
                               logic [15:0] ramp, logic [15:0] air, bit gen, bit beach);
    cfg_write(CFG_PSI_BAND, psi);
    cfg_write(CFG_EPSI_BAND, epsi);
    cfg_write(CFG_EPSI_RECIP, recip);
    cfg_write(CFG_RAMP_GAIN, ramp);
    cfg_write(CFG_AIR_VELOCITY, air);
    cfg_write(CFG_GEN_ENABLE, {15'($urandom), gen});
    cfg_write(CFG_BEACH_ENABLE, {15'($urandom), beach});
    cfg_write(CFG_SPARE_IDX, 16'($urandom));
  endtask

  // Mostly bands sized so the ramp region is reachable, sometimes anything
  task automatic random_setting();
    logic [15:0] ps, ep, rc, rg, av;
    int          q;
    ps = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    ep = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 8192));
    q = 262144 / (int'(ep[14:0]) + 1);
    if ($urandom_range(0, 2) == 0) begin
      rc = 16'($urandom);
    end else begin
      rc = (q > 65535) ? 16'hFFFF : 16'(q);
    end
    rg = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    av = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    apply_setting(ps, ep, rc, rg, av, $urandom_range(0, 3) != 0, 1'($urandom));
  endtask

  function automatic in_item_t make_face(int ph, int pn, int v, int t, int gw, int bw,
                                         bit gz, bit bz);
    in_item_t f;
    f.phi_here = 16'(ph);
    f.phi_next = 16'(pn);
    f.vel_old = 16'(v);
    f.target_vel = 16'(t);
    f.gen_weight = 16'(gw);
    f.beach_weight = 16'(bw);
    f.in_gen_zone = gz;
    f.in_beach_zone = bz;
    return f;
  endfunction

  function automatic logic [15:0] random_vel();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Steer most level-set sums into or near the interface band
  function automatic in_item_t random_face();
    in_item_t f;
    int       lo, s, half, d;
    f.phi_here = 16'($urandom);
    f.phi_next = 16'($urandom);
    if ($urandom_range(0, 9) < 6) begin
      lo = 2 * int'(blend_sb.epsi_w) + 8;
      if (lo > 65535) lo = 65535;
      s = int'($urandom_range(0, 8)) - int'($urandom_range(0, lo));
      half = s >>> 1;
      d = int'($urandom_range(0, 1024)) - 512;
      if (half + d < -32768 || half + d > 32767 || s - half - d < -32768 ||
          s - half - d > 32767) d = 0;
      f.phi_here = 16'(half + d);
      f.phi_next = 16'(s - half - d);
    end
    f.vel_old = random_vel();
    f.target_vel = random_vel();
    f.gen_weight = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    f.beach_weight = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    f.in_gen_zone = 1'($urandom);
    f.in_beach_zone = 1'($urandom);
    return f;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_active = 1'b1;
        stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        hold_active = 1'b0;
        if (idling_on && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 12) - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Check every result transaction taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) blend_sb.check_face(out_data_o);
  end

  // Abort when no channel moves a transaction for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    blend_sb = new();
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zone flags ignored while both relaxations are off
    offer_face(make_face(-512, -512, 32767, -32768, 0, 0, 1, 1));
    offer_face(make_face(-32768, -32768, -32768, 32767, 16'hFFFF, 16'hFFFF, 1, 1));

    // Default bands with both relaxations on: air, water, band edges, ramp
    wait_drained();
    apply_setting(16'd0, 16'd1024, 16'd256, 16'h8000, 16'd0, 1'b1, 1'b1);
    offer_face(make_face(32767, 32767, 1000, -2000, 16384, 32768, 1, 0));
    offer_face(make_face(-32768, -32768, 1000, -2000, 16384, 0, 1, 0));
    offer_face(make_face(-1024, -1024, 3000, 9000, 8192, 0, 1, 0));
    offer_face(make_face(-1025, -1024, 3000, 9000, 8192, 0, 1, 0));
    offer_face(make_face(-5, 5, -700, 700, 0, 0, 1, 0));
    offer_face(make_face(0, -1, -700, 700, 0, 0, 1, 0));
    offer_face(make_face(-300, -400, 32767, -32768, 0, 16'h8000, 1, 1));
    offer_face(make_face(-600, -200, -32768, 32767, 16'hFFFF, 16'hFFFF, 1, 1));
    offer_face(make_face(-700, -100, 5000, 7000, 16'h8000, 0, 1, 1));
    offer_face(make_face(100, 100, -32768, 0, 0, 16'h4000, 0, 1));
    offer_face(make_face(0, 0, 32767, 0, 0, 16'h8000, 0, 1));
    offer_face(make_face(-1, -1, 12345, -1, 16'hFFFF, 16'hFFFF, 0, 0));

    // Inner band wider than outer band, ramp gain above one, most negative air
    wait_drained();
    apply_setting(16'hFFFF, 16'h0100, 16'h1234, 16'hFFFF, 16'h8000, 1'b1, 1'b1);
    offer_face(make_face(-128, -127, 1000, 2000, 16'h2000, 16'h6000, 1, 1));
    offer_face(make_face(-257, -256, 1000, 2000, 16'h2000, 16'h6000, 1, 1));
    offer_face(make_face(32767, -32768, -9000, 2000, 16'h7000, 16'hFFFF, 1, 1));

    // Widest band, zero reciprocal, zero ramp gain, largest air velocity
    wait_drained();
    apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'h7FFF, 1'b1, 1'b1);
    offer_face(make_face(-32768, -32768, 32767, 32767, 0, 16'h8000, 1, 1));
    offer_face(make_face(-32767, -32767, 32767, 32767, 0, 16'h8000, 1, 1));
    offer_face(make_face(-2, -3, -32768, -32768, 100, 16'hFFFF, 1, 1));
    offer_face(make_face(-16384, -16384, 0, 32767, 16'h7FFF, 1, 1, 1));

    // Random sweeps, one register setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: apply_setting(16'h0080, 16'h0800, 16'd128, 16'h6000, 16'h0400, 1'b1, 1'b1);
        1: apply_setting(16'd0, 16'h0400, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0);
        default: random_setting();
      endcase
      idling_on = (p % 3 != 2) && (p != NUM_PHASES - 1);
      for (int i = 0; i < PHASE_FACES; i++) begin
        if (p == PRESSURE_PHASE && i == 20) pressure_req = 1'b1;
        offer_face(random_face());
        if (idling_on && !hold_active && !pressure_req && $urandom_range(0, 3) == 0)
          pause_offer($urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH * 4) @(posedge clk_i);
    if (blend_sb.mismatches == 0 && blend_sb.pending_faces.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
